// ===== design/sspq_pkg.sv =====
// ----------------------------------------------------------------------------
// sspq_pkg
// Sizes, types and helpers shared by the sorted priority queue core, its
// channel interfaces and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sspq_pkg;

   localparam int CAPACITY      = 16;
   localparam int PRIORITY_BITS = 8;
   localparam int PAYLOAD_BITS  = 16;

   localparam int ADDR_BITS  = $clog2(CAPACITY);
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int ENTRY_BITS = PRIORITY_BITS + PAYLOAD_BITS;

   typedef logic [ADDR_BITS-1:0]     addr_type;
   typedef logic [COUNT_BITS-1:0]    count_type;
   typedef logic [PRIORITY_BITS-1:0] priority_type;
   typedef logic [PAYLOAD_BITS-1:0]  payload_type;

   typedef struct packed {
      priority_type prio;
      payload_type  payload;
   } entry_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      CMD_ENQUEUE = 1'b0,
      CMD_DEQUEUE = 1'b1
   } command_type;

   typedef struct packed {
      status_type   status;
      priority_type prio;
      payload_type  payload;
      count_type    count;
      logic         empty;
   } result_type;

   localparam addr_type  ADDR_LAST  = ADDR_BITS'(CAPACITY - 1);
   localparam count_type COUNT_FULL = COUNT_BITS'(CAPACITY);
   localparam count_type COUNT_ONE  = COUNT_BITS'(1);

   // circular buffer index step forward, wrapping at the capacity
   function automatic addr_type addr_next(input addr_type a);
      addr_type r;
      if (a == ADDR_LAST) r = '0;
      else                r = a + addr_type'(1);
      return r;
   endfunction

   // circular buffer index step back, wrapping at the capacity
   function automatic addr_type addr_prev(input addr_type a);
      addr_type r;
      if (a == '0) r = ADDR_LAST;
      else         r = a - addr_type'(1);
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/sspq_if.sv =====
// ----------------------------------------------------------------------------
// sspq channel interfaces
// Request and response channels of the sorted priority queue, each a
// valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface sspq_req_if;
   import sspq_pkg::*;

   logic         valid;
   logic         ready;
   logic         command;
   priority_type entry_priority;
   payload_type  entry_payload;

   modport source (output valid, command, entry_priority, entry_payload, input ready);
   modport sink   (input valid, command, entry_priority, entry_payload, output ready);
endinterface

interface sspq_rsp_if;
   import sspq_pkg::*;

   logic         valid;
   logic         ready;
   status_type   status;
   priority_type out_priority;
   payload_type  out_payload;
   count_type    entry_count;
   logic         is_empty;

   modport source (output valid, status, out_priority, out_payload, entry_count, is_empty,
                   input ready);
   modport sink   (input valid, status, out_priority, out_payload, entry_count, is_empty,
                   output ready);
endinterface

`default_nettype wire

// ===== design/sspq_ram.sv =====
// ----------------------------------------------------------------------------
// sspq_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sspq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/stable_sorted_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_core
// Bounded min-first priority queue. Entries sit in ascending priority order
// in a circular buffer held in one RAM; equal priorities leave in arrival
// order.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+------------------------------------
//   req_if  | in  | valid/ready         | command, entry_priority, entry_payload
//   rsp_if  | out | valid/ready         | status, out_priority, out_payload,
//           |     |                     | entry_count, is_empty
//
// One item at a time. A dequeue reads the head entry, takes the read data in
// S_DEQ, then passes the result through S_EMIT. Refused items and an enqueue
// into an empty queue go straight to S_EMIT. Other enqueues scan back from the
// tail in S_SCAN; the single RAM write port moves one entry a cycle. Reset
// clears the state, pointers, count and response valid only; the RAM needs no
// clearing pass. A stalled response waits in the output register; the next
// item is taken meanwhile and holds in its final state until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_sorted_priority_queue_core (
   input  logic       clock,
   input  logic       reset,
   sspq_req_if.sink   req_if,
   sspq_rsp_if.source rsp_if
);
   import sspq_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_PLACE = 5'b00100,
      S_DEQ   = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   state_type  state_ff,    state_in;
   addr_type   head_ff,     head_in;
   addr_type   tail_ff,     tail_in;
   count_type  count_ff,    count_in;
   addr_type   hole_ff,     hole_in;
   addr_type   rd_ptr_ff,   rd_ptr_in;
   entry_type  new_ff,      new_in;
   result_type res_ff,      res_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   logic      req_transfer;
   logic      rsp_load;
   logic      rd_en;
   addr_type  rd_addr;
   entry_type rd_entry;
   logic      wr_en;
   addr_type  wr_addr;
   entry_type wr_entry;
   entry_type req_entry;
   count_type count_inc;
   count_type count_dec;

   sspq_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_transfer = req_if.valid && req_if.ready;
   assign rsp_load     = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_if.ready);

   assign req_entry.prio    = req_if.entry_priority;
   assign req_entry.payload = req_if.entry_payload;

   assign count_inc = count_ff + COUNT_ONE;
   assign count_dec = count_ff - COUNT_ONE;

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      hole_in   = hole_ff;
      rd_ptr_in = rd_ptr_ff;
      new_in    = new_ff;
      res_in    = res_ff;
      rd_en     = 1'b0;
      rd_addr   = head_ff;
      wr_en     = 1'b0;
      wr_addr   = hole_ff;
      wr_entry  = new_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_transfer) begin
               if (req_if.command == CMD_DEQUEUE) begin
                  if (count_ff == '0) begin
                     res_in   = '{ST_EMPTY, '0, '0, count_ff, 1'b1};
                     state_in = S_EMIT;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = head_ff;
                     state_in = S_DEQ;
                  end
               end else if (count_ff == COUNT_FULL) begin
                  res_in   = '{ST_FULL, '0, '0, count_ff, (count_ff == '0)};
                  state_in = S_EMIT;
               end else if (count_ff == '0) begin
                  // empty queue: drop the entry straight in at the tail
                  wr_en    = 1'b1;
                  wr_addr  = tail_ff;
                  wr_entry = req_entry;
                  tail_in  = addr_next(tail_ff);
                  count_in = count_inc;
                  res_in   = '{ST_OK, '0, '0, count_inc, 1'b0};
                  state_in = S_EMIT;
               end else begin
                  // open a hole at the tail and walk back towards the head
                  new_in    = req_entry;
                  hole_in   = tail_ff;
                  rd_ptr_in = addr_prev(tail_ff);
                  rd_en     = 1'b1;
                  rd_addr   = addr_prev(tail_ff);
                  state_in  = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            wr_en   = 1'b1;
            wr_addr = hole_ff;
            if (rd_entry.prio > new_ff.prio) begin
               // move the larger entry up into the hole, hole moves down
               wr_entry = rd_entry;
               hole_in  = rd_ptr_ff;
               if (rd_ptr_ff == head_ff) begin
                  state_in = S_PLACE;
               end else begin
                  rd_ptr_in = addr_prev(rd_ptr_ff);
                  rd_en     = 1'b1;
                  rd_addr   = addr_prev(rd_ptr_ff);
               end
            end else begin
               wr_entry = new_ff;
               tail_in  = addr_next(tail_ff);
               count_in = count_inc;
               res_in   = '{ST_OK, '0, '0, count_inc, 1'b0};
               state_in = S_EMIT;
            end
         end

         S_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = hole_ff;
            wr_entry = new_ff;
            tail_in  = addr_next(tail_ff);
            count_in = count_inc;
            res_in   = '{ST_OK, '0, '0, count_inc, 1'b0};
            state_in = S_EMIT;
         end

         S_DEQ: begin
            head_in  = addr_next(head_ff);
            count_in = count_dec;
            res_in   = '{ST_OK, rd_entry.prio, rd_entry.payload, count_dec,
                         (count_ff == COUNT_ONE)};
            state_in = S_EMIT;
         end

         S_EMIT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_data_in  = res_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hole_ff     <= hole_in;
      rd_ptr_ff   <= rd_ptr_in;
      new_ff      <= new_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_data_ff.status;
   assign rsp_if.out_priority = rsp_data_ff.prio;
   assign rsp_if.out_payload  = rsp_data_ff.payload;
   assign rsp_if.entry_count  = rsp_data_ff.count;
   assign rsp_if.is_empty     = rsp_data_ff.empty;

endmodule

`default_nettype wire

// ===== design/sspq_checker.sv =====
// ----------------------------------------------------------------------------
// sspq_checker
// Port-level checks on the response channel of the sorted priority queue,
// bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module sspq_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input sspq_pkg::status_type rsp_status,
   input sspq_pkg::priority_type rsp_priority,
   input sspq_pkg::payload_type  rsp_payload,
   input sspq_pkg::count_type    rsp_count,
   input logic                 rsp_empty
);
   import sspq_pkg::*;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count) && $stable(rsp_status))
      else $error("response dropped or changed while stalled");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_empty == (rsp_count == '0)))
      else $error("empty flag disagrees with entry count");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count <= COUNT_FULL))
      else $error("entry count beyond capacity");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY || rsp_status == ST_FULL)
         |-> (rsp_priority == '0) && (rsp_payload == '0))
      else $error("refused item returned entry data");

   a_status_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_count == COUNT_FULL)
      else $error("full refusal while queue not full");

endmodule

bind stable_sorted_priority_queue_core sspq_checker u_sspq_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_status   (rsp_if.status),
   .rsp_priority (rsp_if.out_priority),
   .rsp_payload  (rsp_if.out_payload),
   .rsp_count    (rsp_if.entry_count),
   .rsp_empty    (rsp_if.is_empty)
);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stable sorted priority queue core. A directed
// table covers the empty, full, tie and extreme cases. Random enqueue and
// dequeue runs follow, with phases that alternately fill and drain the queue.
// An in-bench model of the sorted store predicts every response that the
// table does not give; random gaps hit both the request and response handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import sspq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_OPS    = 1900;
   localparam int DIRECTED_ROWS = 25;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 60;

   typedef struct packed {
      command_type  cmd;
      priority_type prio;
      payload_type  payload;
      logic         typed;
      result_type   want;
   } stim_row_type;

   logic clock;
   logic reset;

   sspq_req_if req_bus ();
   sspq_rsp_if rsp_bus ();

   stable_sorted_priority_queue_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // model of the sorted store, front at index 0
   priority_type model_prio [CAPACITY];
   payload_type  model_payload [CAPACITY];
   int           model_count;

   result_type   awaited_outcomes [$];
   int           error_count;
   int           cycles_without_transfer;
   bit           quiet_stretch;
   int           rsp_stall_left;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{CMD_DEQUEUE, 8'h00, 16'h0000, 1'b1, '{ST_EMPTY, 8'h00, 16'h0000, count_type'(0), 1'b1}},
      '{CMD_ENQUEUE, 8'hFF, 16'hFFFF, 1'b1, '{ST_OK, 8'h00, 16'h0000, count_type'(1), 1'b0}},
      '{CMD_ENQUEUE, 8'h00, 16'h0000, 1'b1, '{ST_OK, 8'h00, 16'h0000, count_type'(2), 1'b0}},
      '{CMD_DEQUEUE, 8'hFF, 16'hFFFF, 1'b1, '{ST_OK, 8'h00, 16'h0000, count_type'(1), 1'b0}},
      '{CMD_DEQUEUE, 8'h00, 16'h0000, 1'b1, '{ST_OK, 8'hFF, 16'hFFFF, count_type'(0), 1'b1}},
      '{CMD_DEQUEUE, 8'hFF, 16'hFFFF, 1'b1, '{ST_EMPTY, 8'h00, 16'h0000, count_type'(0), 1'b1}},
      '{CMD_ENQUEUE, 8'h80, 16'h1001, 1'b0, '0},
      '{CMD_ENQUEUE, 8'h10, 16'h1002, 1'b0, '0},
      '{CMD_ENQUEUE, 8'h80, 16'h1003, 1'b0, '0},
      '{CMD_ENQUEUE, 8'hFF, 16'hAAAA, 1'b0, '0},
      '{CMD_ENQUEUE, 8'h00, 16'h5555, 1'b0, '0},
      '{CMD_ENQUEUE, 8'h80, 16'h1006, 1'b0, '0},
      '{CMD_ENQUEUE, 8'h10, 16'h1007, 1'b0, '0},
      '{CMD_ENQUEUE, 8'hFF, 16'h0000, 1'b0, '0},
      '{CMD_ENQUEUE, 8'h00, 16'hFFFF, 1'b0, '0},
      '{CMD_ENQUEUE, 8'h7F, 16'h100A, 1'b0, '0},
      '{CMD_ENQUEUE, 8'h80, 16'h100B, 1'b0, '0},
      '{CMD_ENQUEUE, 8'h10, 16'h100C, 1'b0, '0},
      '{CMD_ENQUEUE, 8'h01, 16'h100D, 1'b0, '0},
      '{CMD_ENQUEUE, 8'hFE, 16'h100E, 1'b0, '0},
      '{CMD_ENQUEUE, 8'h80, 16'h100F, 1'b0, '0},
      '{CMD_ENQUEUE, 8'h00, 16'h1010, 1'b0, '0},
      '{CMD_ENQUEUE, 8'h55, 16'h7777, 1'b1, '{ST_FULL, 8'h00, 16'h0000, count_type'(16), 1'b0}},
      '{CMD_DEQUEUE, 8'hAA, 16'hABCD, 1'b0, '0},
      '{CMD_ENQUEUE, 8'hFF, 16'hFEED, 1'b0, '0}
   };

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // mostly short gaps, a few long ones, none at all during a quiet stretch
   function automatic int pick_gap();
      int r;
      int gap;
      r = $urandom_range(0, 99);
      if (quiet_stretch)  gap = 0;
      else if (r < 60)    gap = 0;
      else if (r < 90)    gap = $urandom_range(1, 3);
      else if (r < 98)    gap = $urandom_range(4, 10);
      else                gap = $urandom_range(20, 60);
      return gap;
   endfunction

   function automatic result_type apply_queue_op(command_type cmd, priority_type prio,
                                                 payload_type payload);
      result_type r;
      int pos;
      int i;
      r.status  = ST_OK;
      r.prio    = '0;
      r.payload = '0;
      if (cmd == CMD_ENQUEUE) begin
         if (model_count >= CAPACITY) begin
            r.status = ST_FULL;
         end else begin
            // insert behind every entry of equal or lower priority
            pos = 0;
            while (pos < model_count && model_prio[pos] <= prio) pos++;
            for (i = model_count; i > pos; i--) begin
               model_prio[i]    = model_prio[i-1];
               model_payload[i] = model_payload[i-1];
            end
            model_prio[pos]    = prio;
            model_payload[pos] = payload;
            model_count++;
         end
      end else if (model_count == 0) begin
         r.status = ST_EMPTY;
      end else begin
         r.prio    = model_prio[0];
         r.payload = model_payload[0];
         for (i = 1; i < model_count; i++) begin
            model_prio[i-1]    = model_prio[i];
            model_payload[i-1] = model_payload[i];
         end
         model_count--;
      end
      r.count = count_type'(model_count);
      r.empty = (model_count == 0);
      return r;
   endfunction

   // returns at the edge where the transfer happens, without advancing time
   task automatic transfer_request(command_type cmd, priority_type prio, payload_type payload);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.command        <= cmd;
      req_bus.entry_priority <= prio;
      req_bus.entry_payload  <= payload;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // response side: check each transfer, then choose the next ready level
   always @(posedge clock) begin
      result_type want;
      int gap;
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         cycles_without_transfer = 0;
      else
         cycles_without_transfer++;

      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_outcomes.size() == 0) begin
               $display("%0t: response with no request outstanding", $time);
               error_count++;
            end else begin
               want = awaited_outcomes.pop_front();
               compare_field("status", want.status, rsp_bus.status);
               compare_field("out_priority", want.prio, rsp_bus.out_priority);
               compare_field("out_payload", want.payload, rsp_bus.out_payload);
               compare_field("entry_count", want.count, rsp_bus.entry_count);
               compare_field("is_empty", want.empty, rsp_bus.is_empty);
            end
         end
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            if (gap > 0) begin
               rsp_stall_left = gap - 1;
               rsp_bus.ready <= 1'b0;
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   initial begin
      while (cycles_without_transfer < STALL_LIMIT) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      result_type   outcome;
      command_type  cmd;
      priority_type prio;
      payload_type  payload;
      int           enq_weight;
      int           r;

      error_count             = 0;
      cycles_without_transfer = 0;
      quiet_stretch           = 1'b0;
      rsp_stall_left          = 0;
      model_count             = 0;
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.command         = CMD_ENQUEUE;
      req_bus.entry_priority  = '0;
      req_bus.entry_payload   = '0;
      rsp_bus.ready           = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[k]) begin
         transfer_request(directed_rows[k].cmd, directed_rows[k].prio,
                          directed_rows[k].payload);
         outcome = apply_queue_op(directed_rows[k].cmd, directed_rows[k].prio,
                                  directed_rows[k].payload);
         awaited_outcomes.push_back(directed_rows[k].typed ? directed_rows[k].want : outcome);
      end

      for (int n = 0; n < RANDOM_OPS; n++) begin
         // hold off until the queue core has answered everything
         if (n % 500 == 0) begin
            req_bus.valid <= 1'b0;
            while (awaited_outcomes.size() != 0) @(posedge clock);
         end
         quiet_stretch = ((n / 150) % 5 == 2);
         // alternate filling, balanced and draining phases
         case ((n / 100) % 4)
            0: enq_weight = 80;
            1: enq_weight = 50;
            2: enq_weight = 20;
            default: enq_weight = 65;
         endcase
         cmd = ($urandom_range(0, 99) < enq_weight) ? CMD_ENQUEUE : CMD_DEQUEUE;
         r = $urandom_range(0, 99);
         if (r < 40)      prio = priority_type'($urandom_range(0, 3));
         else if (r < 50) prio = $urandom_range(0, 1) ? '1 : '0;
         else             prio = priority_type'($urandom());
         r = $urandom_range(0, 19);
         if (r == 0)      payload = '0;
         else if (r == 1) payload = '1;
         else             payload = payload_type'($urandom());
         transfer_request(cmd, prio, payload);
         awaited_outcomes.push_back(apply_queue_op(cmd, prio, payload));
      end

      req_bus.valid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== stable_sorted_priority_queue_core.f =====
design/sspq_pkg.sv
design/sspq_if.sv
design/sspq_ram.sv
design/stable_sorted_priority_queue_core.sv
design/sspq_checker.sv
tb/tb.sv
